### rtl/oss_pkg.sv
// ----------------------------------------------------------------------------
// oss_pkg: shared types and constants of the oversampled soft saturator
// Fixed-point widths, chain geometry, filter coefficients and helpers.
// ----------------------------------------------------------------------------
package oss_pkg;

  localparam int OVERSAMPLE    = 8;
  localparam int FILTER_STAGES = 6;
  localparam int DC_STAGES     = 2;
  localparam int NUM_CELLS     = 2 * FILTER_STAGES + DC_STAGES + 1;

  // one beat per sub-sample hop, long enough for the bit-serial divider
  localparam int BEAT_LEN   = 32;
  localparam int BEAT_W     = $clog2(BEAT_LEN);
  localparam int CLIP_ITERS = 30;

  localparam int SIG_W  = 48;
  localparam int COEF_W = 32;
  localparam int SMP_W  = 24;
  localparam int GAIN_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DC_B0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DC_B1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DC_B2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DC_A1      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DC_A2      = 3'd6;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  // sideband that travels with each sub-sample
  typedef struct packed {
    logic                    valid;
    logic                    final_sub;
    logic                    last;
    logic signed [SMP_W-1:0] sample;
  } meta_t;

  // shared beat timing
  typedef struct packed {
    logic [BEAT_W-1:0] cnt;
    logic              adv;
  } beat_t;

  localparam coef_t DC_RESET = '{
    b0: 32'sd1073697903, b1: 32'sd0, b2: -32'sd1073697903,
    a1: 32'sd87842, a2: -32'sd1073653982};

  function automatic coef_t fixed_coef(input int stage);
    coef_t c;
    c = '{b0: 32'sd1073741824, b1: 32'sd0, b2: 32'sd0, a1: 32'sd0, a2: 32'sd0};
    unique case (stage)
      0: c = '{b0: 32'sd27991, b1: 32'sd32072, b2: 32'sd27991,
               a1: -32'sd1416104405, a2: 32'sd469399123};
      1: c = '{b0: 32'sd1073741824, b1: -32'sd859268337, b2: 32'sd1073741824,
               a1: -32'sd1484995680, a2: 32'sd533194420};
      2: c = '{b0: 32'sd1073741824, b1: -32'sd1525604596, b2: 32'sd1073741824,
               a1: -32'sd1597588248, a2: 32'sd638246099};
      3: c = '{b0: 32'sd1073741824, b1: -32'sd1758144863, b2: 32'sd1073741824,
               a1: -32'sd1725374262, a2: 32'sd759287941};
      4: c = '{b0: 32'sd1073741824, b1: -32'sd1853385762, b2: 32'sd1073741824,
               a1: -32'sd1852526769, a2: 32'sd882783283};
      5: c = '{b0: 32'sd1073741824, b1: -32'sd1889774873, b2: 32'sd1073741824,
               a1: -32'sd1976876810, a2: 32'sd1008040636};
      default: c = '{b0: 32'sd1073741824, b1: 32'sd0, b2: 32'sd0,
                     a1: 32'sd0, a2: 32'sd0};
    endcase
    return c;
  endfunction

  function automatic logic signed [SIG_W-1:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd140737488355327;
    lo = -64'sd140737488355328;
    if (v > hi) return hi[SIG_W-1:0];
    if (v < lo) return lo[SIG_W-1:0];
    return v[SIG_W-1:0];
  endfunction

endpackage

### rtl/oversampled_soft_saturator.sv
// ----------------------------------------------------------------------------
// oversampled_soft_saturator: 8x oversampled soft clipper with filtering
// Drive, zero-stuffing, anti-imaging, x/(1+|x|), dc blocking and anti-alias
// filtering on a systolic row of cells that hand sub-samples on every beat.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata[23:0] sample_in, tlast last_in_block
//  m_axis    | out       | tdata[23:0] sample_out, tlast last_out
//  cfg       | in        | cfg_idx_i register index, cfg_data_i value
//
// the row advances one cell per beat, whose length is set by the clipper's
// bit-serial divider; a sample feeds 8 sub-samples, and the next sample is
// taken once the last of them has left the injector
// reset clears all filter state and the valid marks at once
// when the next result is due, a waiting result that is not taken freezes the whole row at the beat end
// ----------------------------------------------------------------------------
module oversampled_soft_saturator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [oss_pkg::SMP_W-1:0]         s_axis_tdata,   // [23:0] sample_in
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [oss_pkg::SMP_W-1:0]         m_axis_tdata,   // [23:0] sample_out
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [oss_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [oss_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import oss_pkg::*;

  localparam int K_W = $clog2(OVERSAMPLE);
  localparam logic [K_W-1:0] K_LAST = K_W'(OVERSAMPLE - 1);

  // configuration registers
  logic [GAIN_W-1:0] drive_q;
  logic              bypass_q;
  coef_t             dc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q  <= GAIN_W'(65536);
      bypass_q <= 1'b0;
      dc_q     <= DC_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DRIVE_GAIN: drive_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_BYPASS:     bypass_q <= cfg_data_i[0];
        CFG_DC_B0:      dc_q.b0  <= cfg_data_i;
        CFG_DC_B1:      dc_q.b1  <= cfg_data_i;
        CFG_DC_B2:      dc_q.b2  <= cfg_data_i;
        CFG_DC_A1:      dc_q.a1  <= cfg_data_i;
        CFG_DC_A2:      dc_q.a2  <= cfg_data_i;
        default:        ;  // unused index, write dropped
      endcase
    end
  end

  // beat timing shared by every cell
  logic [BEAT_W-1:0] cnt_q, cnt_d;
  beat_t             beat;
  logic              stall;

  // links between cells: link 0 from the injector, link i+1 from cell i
  logic signed [SIG_W-1:0] link_x [NUM_CELLS+1];
  meta_t                   link_m [NUM_CELLS+1];

  // output register
  logic              out_valid_q;
  logic [SMP_W-1:0]  out_data_q;
  logic              out_last_q;
  logic              out_load;

  assign stall = link_m[NUM_CELLS].valid && link_m[NUM_CELLS].final_sub &&
                 out_valid_q && !m_axis_tready;
  assign beat.cnt = cnt_q;
  assign beat.adv = (cnt_q == BEAT_W'(BEAT_LEN - 1)) && !stall;

  always_comb begin
    if (cnt_q == BEAT_W'(BEAT_LEN - 1)) cnt_d = beat.adv ? '0 : cnt_q;
    else                                cnt_d = cnt_q + BEAT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  // input side: drive gain, then hold the stuffed sub-sample stream
  logic                    inj_busy_q;
  logic [K_W-1:0]          inj_k_q;
  logic signed [SIG_W-1:0] inj_f_q;
  logic signed [SMP_W-1:0] inj_s_q;
  logic                    inj_last_q;
  logic                    s_acc;
  logic signed [48:0]      drv_prod;
  logic signed [48:0]      drv_round;
  logic signed [63:0]      drv_os;

  assign s_axis_tready = !inj_busy_q;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    drv_prod  = $signed(s_axis_tdata) * $signed({1'b0, drive_q});
    drv_round = (drv_prod + 49'sd256) >>> 9;
    drv_os    = 64'(drv_round) * 64'(OVERSAMPLE);
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      inj_f_q    <= sat48(drv_os);
      inj_s_q    <= s_axis_tdata;
      inj_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inj_busy_q <= 1'b0;
      inj_k_q    <= '0;
    end else if (s_acc) begin
      inj_busy_q <= 1'b1;
      inj_k_q    <= '0;
    end else if (inj_busy_q && beat.adv) begin
      inj_k_q <= inj_k_q + K_W'(1);
      if (inj_k_q == K_LAST) inj_busy_q <= 1'b0;
    end
  end

  // only the first sub-sample carries the value, the rest are zero stuffing
  assign link_x[0] = (inj_k_q == '0) ? inj_f_q : '0;
  assign link_m[0] = '{valid: inj_busy_q, final_sub: (inj_k_q == K_LAST),
                       last: inj_last_q, sample: inj_s_q};

  // the row: anti-imaging, clipper, dc blockers, anti-alias
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i == FILTER_STAGES) begin : g_clip
      oss_clip_cell u_clip (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .beat_i (beat),
        .x_i    (link_x[i]),
        .meta_i (link_m[i]),
        .y_o    (link_x[i+1]),
        .meta_o (link_m[i+1])
      );
    end else begin : g_bq
      coef_t coef;
      if (i < FILTER_STAGES) begin : g_img
        assign coef = fixed_coef(i);
      end else if (i <= FILTER_STAGES + DC_STAGES) begin : g_dc
        assign coef = dc_q;
      end else begin : g_aa
        assign coef = fixed_coef(i - FILTER_STAGES - DC_STAGES - 1);
      end
      oss_biquad_cell u_bq (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .beat_i (beat),
        .coef_i (coef),
        .x_i    (link_x[i]),
        .meta_i (link_m[i]),
        .y_o    (link_x[i+1]),
        .meta_o (link_m[i+1])
      );
    end
  end

  // output: round Q.30 to Q.23 and saturate, or pass the dry sample
  logic signed [48:0] fin_round;
  logic signed [41:0] fin_shift;
  logic [SMP_W-1:0]   fin_data;

  always_comb begin
    fin_round = 49'(link_x[NUM_CELLS]) + 49'sd64;
    fin_shift = 42'(fin_round >>> 7);
    if (bypass_q)                         fin_data = link_m[NUM_CELLS].sample;
    else if (fin_shift > 42'sd8388607)    fin_data = 24'h7fffff;
    else if (fin_shift < -42'sd8388608)   fin_data = 24'h800000;
    else                                  fin_data = fin_shift[SMP_W-1:0];
  end

  assign out_load = beat.adv && link_m[NUM_CELLS].valid && link_m[NUM_CELLS].final_sub;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= fin_data;
      out_last_q <= link_m[NUM_CELLS].last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                       out_valid_q <= 1'b0;
    else if (out_load)                 out_valid_q <= 1'b1;
    else if (m_axis_tready)            out_valid_q <= 1'b0;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("result overwritten");

  // the row only moves at the end of a beat
  a_adv_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat.adv |-> (cnt_q == BEAT_W'(BEAT_LEN - 1)))
    else $error("advance inside a beat");

  // the injector frees up right after its last sub-sample
  a_inj_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inj_busy_q && beat.adv && inj_k_q == K_LAST && !s_acc) |=> !inj_busy_q)
    else $error("injector stuck after last sub-sample");

  // no new sample is taken while sub-samples remain
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inj_busy_q && !(beat.adv && inj_k_q == K_LAST)) |=> !s_axis_tready)
    else $error("input accepted while busy");
`endif

endmodule

### rtl/oss_biquad_cell.sv
// ----------------------------------------------------------------------------
// oss_biquad_cell: one transposed direct form II biquad of the chain
// One shared 32x25 multiplier, ten half-products per beat, own two states.
// ----------------------------------------------------------------------------
module oss_biquad_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  oss_pkg::beat_t                    beat_i,
  input  oss_pkg::coef_t                    coef_i,
  input  logic signed [oss_pkg::SIG_W-1:0]  x_i,
  input  oss_pkg::meta_t                    meta_i,
  output logic signed [oss_pkg::SIG_W-1:0]  y_o,
  output oss_pkg::meta_t                    meta_o
);
  import oss_pkg::*;

  logic signed [SIG_W-1:0]  x_q;
  meta_t                    meta_q;
  logic signed [SIG_W-1:0]  s0_q, s1_q, y_q;
  logic signed [56:0]       p_q, h_q;
  logic signed [49:0]       r_q;
  logic signed [51:0]       a_q;

  logic signed [COEF_W-1:0] m_coef;
  logic signed [SIG_W-1:0]  m_sig;
  logic                     m_lo;
  logic signed [24:0]       m_opnd;
  logic signed [57:0]       t_sum, cm_sum;

  // product schedule: b0*x, b1*x, a1*y, b2*x, a2*y, hi half then lo half
  always_comb begin
    m_coef = coef_i.b0;
    m_sig  = x_q;
    m_lo   = beat_i.cnt[0];
    unique case (beat_i.cnt[BEAT_W-1:1])
      'd0:     m_coef = coef_i.b0;
      'd1:     m_coef = coef_i.b1;
      'd2:     begin m_coef = coef_i.a1; m_sig = y_q; end
      'd3:     m_coef = coef_i.b2;
      'd4:     begin m_coef = coef_i.a2; m_sig = y_q; end
      default: m_coef = coef_i.b0;
    endcase
    m_opnd = m_lo ? $signed({1'b0, m_sig[23:0]}) : $signed({m_sig[47], m_sig[47:24]});
  end

  // rounded recombination of the two halves
  always_comb begin
    t_sum  = $signed({28'b0, h_q[5:0], 24'b0}) + 58'(p_q) + 58'sd536870912;
    cm_sum = 58'(h_q >>> 6) + (t_sum >>> 30);
  end

  always_ff @(posedge clk_i) begin
    p_q <= m_coef * m_opnd;
    if (beat_i.cnt[0] && beat_i.cnt <= BEAT_W'(9)) h_q <= p_q;
    if (!beat_i.cnt[0] && beat_i.cnt >= BEAT_W'(2) && beat_i.cnt <= BEAT_W'(10))
      r_q <= cm_sum[49:0];
    if (beat_i.cnt == BEAT_W'(3)) y_q <= sat48(64'(s0_q) + 64'(r_q));
    if (beat_i.cnt == BEAT_W'(5)) a_q <= 52'(s1_q) + 52'(r_q);
    if (beat_i.cnt == BEAT_W'(9)) a_q <= 52'(r_q);
    if (beat_i.adv) x_q <= x_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
      s0_q   <= '0;
      s1_q   <= '0;
    end else begin
      if (beat_i.adv) meta_q <= meta_i;
      if (meta_q.valid && beat_i.cnt == BEAT_W'(7))
        s0_q <= sat48(64'(a_q) - 64'(r_q));
      if (meta_q.valid && beat_i.cnt == BEAT_W'(11))
        s1_q <= sat48(64'(a_q) - 64'(r_q));
    end
  end

  assign y_o    = y_q;
  assign meta_o = meta_q;

endmodule

### rtl/oss_clip_cell.sv
// ----------------------------------------------------------------------------
// oss_clip_cell: soft clipper x/(1+|x|) of the chain
// Restoring divider, one quotient bit per cycle, rounded on the last step.
// ----------------------------------------------------------------------------
module oss_clip_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  oss_pkg::beat_t                    beat_i,
  input  logic signed [oss_pkg::SIG_W-1:0]  x_i,
  input  oss_pkg::meta_t                    meta_i,
  output logic signed [oss_pkg::SIG_W-1:0]  y_o,
  output oss_pkg::meta_t                    meta_o
);
  import oss_pkg::*;

  logic signed [SIG_W-1:0] x_q, y_q;
  meta_t                   meta_q;
  logic [48:0]             rem_q;
  logic [29:0]             quo_q;

  logic [SIG_W-1:0] mag;
  logic [48:0]      den, src;
  logic [49:0]      shl;
  logic             ge;
  logic [30:0]      qr;

  always_comb begin
    mag = x_q[SIG_W-1] ? SIG_W'(-x_q) : x_q;
    den = {1'b0, mag} + 49'd1073741824;
    src = (beat_i.cnt == '0) ? {1'b0, mag} : rem_q;
    shl = {src, 1'b0};
    ge  = shl >= {1'b0, den};
    qr  = {1'b0, quo_q} + 31'({rem_q, 1'b0} >= {1'b0, den});
  end

  always_ff @(posedge clk_i) begin
    if (beat_i.cnt < BEAT_W'(CLIP_ITERS)) begin
      rem_q <= ge ? 49'(shl - {1'b0, den}) : shl[48:0];
      quo_q <= (beat_i.cnt == '0) ? 30'(ge) : {quo_q[28:0], ge};
    end
    if (beat_i.cnt == BEAT_W'(CLIP_ITERS))
      y_q <= x_q[SIG_W-1] ? -SIG_W'(qr) : SIG_W'(qr);
    if (beat_i.adv) x_q <= x_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else if (beat_i.adv) begin
      meta_q <= meta_i;
    end
  end

  assign y_o    = y_q;
  assign meta_o = meta_q;

endmodule
